// File: sv/quat_yaw_unwrap_tracker_macros.svh
// Assertion macros used by the checker file of the yaw tracker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef QUAT_YAW_UNWRAP_TRACKER_MACROS_SVH
`define QUAT_YAW_UNWRAP_TRACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QYU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QYU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/qyu_pkg.sv
// Shared constants, types and the arctangent table of the yaw tracker.
// Used by qyu_cordic, quat_yaw_unwrap_tracker and qyu_checker; no dependencies.
package qyu_pkg;

  localparam int CORDIC_STEPS    = 20;
  localparam int ANGLE_FRAC_BITS = 16;

  localparam int TAB_FRAC  = 24;
  localparam int TAB_DEPTH = 32;
  localparam int TAB_IDX_W = $clog2(TAB_DEPTH);
  localparam int STEP_W    = TAB_IDX_W + 1;

  localparam int IN_W     = 32;
  localparam int PROD_W   = 2 * IN_W;
  localparam int QFRAC    = 30;
  localparam int SQ_W     = PROD_W - QFRAC;
  localparam int TERM_W   = SQ_W + 2;
  localparam int RAD_W    = 2 * QFRAC + 1;
  localparam int XY_SCALE = 20;
  localparam int XY_W     = 60;
  localparam int ANG_W    = 34;
  localparam int YAW_W    = 25;
  localparam int DIFF_W   = YAW_W + 2;
  localparam int SUM_W    = 40;
  localparam int ROUND_SH = TAB_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [ANG_W-1:0] HALF_TURN_TAB = ANG_W'(64'd180 << TAB_FRAC);
  localparam logic signed [ANG_W-1:0] ANG_LIM       = ANG_W'(64'd180 << ANGLE_FRAC_BITS);
  localparam logic signed [ANG_W-1:0] ROUND_ADD     =
    (ROUND_SH > 0) ? ANG_W'(64'd1 << (ROUND_SH - 1)) : '0;
  localparam logic signed [YAW_W-1:0] YAW_LIM       = YAW_W'(64'd180 << ANGLE_FRAC_BITS);

  // atan(2^-i) in degrees, Q24, rounded
  localparam logic [31:0] ATAN_TAB [TAB_DEPTH] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115,       32'd57,
    32'd29,        32'd14,        32'd7,         32'd4,         32'd2,
    32'd1,         32'd0
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_W2,
    ST_SQRT,
    ST_MULW,
    ST_TERMS,
    ST_START,
    ST_WAIT,
    ST_UNWRAP,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_ROUND
  } cordic_state_e;

  typedef struct packed {
    logic                    done;
    logic signed [YAW_W-1:0] yaw;
  } cordic_res_t;

endpackage

// File: sv/qyu_cordic.sv
// Iterative vectoring CORDIC giving atan2(num, den) in degrees, one rotation per cycle.
// Depends on qyu_pkg for widths, the arctangent table and the state type.
module qyu_cordic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [qyu_pkg::TERM_W-1:0]    num_i,
  input  logic signed [qyu_pkg::TERM_W-1:0]    den_i,
  output qyu_pkg::cordic_res_t                 res_o
);

  qyu_pkg::cordic_state_e state_q, state_d;

  logic signed [qyu_pkg::XY_W-1:0]   x_q, x_d, y_q, y_d;
  logic signed [qyu_pkg::XY_W-1:0]   x_sh, y_sh, x_init, y_init;
  logic signed [qyu_pkg::TERM_W-1:0] num_adj, den_adj;
  logic signed [qyu_pkg::ANG_W-1:0]  ang_q, ang_d, ang_step, ang_rnd;
  logic [qyu_pkg::STEP_W-1:0]        cnt_q, cnt_d;
  logic [qyu_pkg::TAB_IDX_W-1:0]     idx;
  logic signed [qyu_pkg::YAW_W-1:0]  yaw_q, yaw_d;
  logic                              done_q, done_d;

  assign idx      = cnt_q[qyu_pkg::TAB_IDX_W-1:0];
  assign x_sh     = x_q >>> idx;
  assign y_sh     = y_q >>> idx;
  assign ang_step = $signed(qyu_pkg::ANG_W'(qyu_pkg::ATAN_TAB[idx]));
  assign ang_rnd  = (ang_q + qyu_pkg::ROUND_ADD) >>> qyu_pkg::ROUND_SH;

  // fold the left half-plane onto the right one before iterating
  assign num_adj = (den_i < 0) ? -num_i : num_i;
  assign den_adj = (den_i < 0) ? -den_i : den_i;
  assign x_init  = qyu_pkg::XY_W'(den_adj) <<< qyu_pkg::XY_SCALE;
  assign y_init  = qyu_pkg::XY_W'(num_adj) <<< qyu_pkg::XY_SCALE;

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    ang_d   = ang_q;
    cnt_d   = cnt_q;
    yaw_d   = yaw_q;
    done_d  = 1'b0;
    unique case (state_q)
      qyu_pkg::CS_IDLE: begin
        if (start_i) begin
          if (num_i == '0) begin
            yaw_d  = (den_i < 0) ? qyu_pkg::YAW_LIM : '0;
            done_d = 1'b1;
          end else begin
            x_d   = x_init;
            y_d   = y_init;
            cnt_d = '0;
            if (den_i < 0) begin
              ang_d = (num_i > 0) ? qyu_pkg::HALF_TURN_TAB : -qyu_pkg::HALF_TURN_TAB;
            end else begin
              ang_d = '0;
            end
            state_d = qyu_pkg::CS_RUN;
          end
        end
      end
      qyu_pkg::CS_RUN: begin
        if (y_q > 0) begin
          x_d   = x_q + y_sh;
          y_d   = y_q - x_sh;
          ang_d = ang_q + ang_step;
        end else begin
          x_d   = x_q - y_sh;
          y_d   = y_q + x_sh;
          ang_d = ang_q - ang_step;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == qyu_pkg::STEP_W'(qyu_pkg::CORDIC_STEPS - 1)) begin
          state_d = qyu_pkg::CS_ROUND;
        end
      end
      qyu_pkg::CS_ROUND: begin
        if (ang_rnd > qyu_pkg::ANG_LIM) begin
          yaw_d = qyu_pkg::YAW_LIM;
        end else if (ang_rnd < -qyu_pkg::ANG_LIM) begin
          yaw_d = -qyu_pkg::YAW_LIM;
        end else begin
          yaw_d = qyu_pkg::YAW_W'(ang_rnd);
        end
        done_d  = 1'b1;
        state_d = qyu_pkg::CS_IDLE;
      end
      default: state_d = qyu_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qyu_pkg::CS_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    ang_q <= ang_d;
    yaw_q <= yaw_d;
  end

  assign res_o.done = done_q;
  assign res_o.yaw  = yaw_q;

endmodule

// File: sv/quat_yaw_unwrap_tracker.sv
// Top level of the quaternion yaw tracker: sequencer, shared multiplier, square root
// and unwrap state. Depends on qyu_pkg and instantiates qyu_cordic.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per sample: opcode_i and
//   the Q30 vector part quat_v1_i..quat_v3_i. Opcode 0 is a sample, opcode 1 takes the
//   present unwrapped yaw as the new zero and ignores the vector fields.
//   Output channel (out_valid_o / out_stall_i) returns exactly one beat per input beat:
//   yaw_relative_o (Q16 degrees, unwrapped, minus zero), yaw_wrapped_o, first_sample_o
//   and saturated_o.
//   A zero command goes straight from acceptance to the output register, and a sample
//   whose atan2 numerator is zero skips the CORDIC rotations. The block works on one
//   beat at a time. A sample passes through the 31-step bit-serial square root and the
//   20 CORDIC rotations, with five products taken through a single 32x32 multiplier.
//   A finished result sits in the output register; the next beat is accepted while it
//   waits. If the receiver stalls, the result holds and the sequencer parks in its last
//   state until the register frees up.
//   Reset clears the previous-yaw, unwrapped sum and zero offset; the first sample
//   after reset only records the yaw and reports first_sample_o.
module quat_yaw_unwrap_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic signed [qyu_pkg::IN_W-1:0]     quat_v1_i,
  input  logic signed [qyu_pkg::IN_W-1:0]     quat_v2_i,
  input  logic signed [qyu_pkg::IN_W-1:0]     quat_v3_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [qyu_pkg::SUM_W-1:0]    yaw_relative_o,
  output logic signed [qyu_pkg::YAW_W-1:0]    yaw_wrapped_o,
  output logic                                first_sample_o,
  output logic                                saturated_o
);

  localparam int MUL_CNT_W = 3;
  localparam logic [MUL_CNT_W-1:0] PRD_V11  = 3'd0;
  localparam logic [MUL_CNT_W-1:0] PRD_V22  = 3'd1;
  localparam logic [MUL_CNT_W-1:0] PRD_V33  = 3'd2;
  localparam logic [MUL_CNT_W-1:0] PRD_V12  = 3'd3;
  localparam logic [MUL_CNT_W-1:0] PRD_LAST = 3'd4;

  localparam int SUM_EXT_W = qyu_pkg::SUM_W + 1;
  localparam logic signed [qyu_pkg::TERM_W-1:0] TERM_ONE =
    qyu_pkg::TERM_W'(64'd1 << qyu_pkg::QFRAC);
  localparam logic signed [qyu_pkg::DIFF_W-1:0] HALF_DIFF =
    qyu_pkg::DIFF_W'(64'd180 << qyu_pkg::ANGLE_FRAC_BITS);
  localparam logic signed [qyu_pkg::DIFF_W-1:0] FULL_DIFF =
    qyu_pkg::DIFF_W'(64'd360 << qyu_pkg::ANGLE_FRAC_BITS);
  localparam logic signed [qyu_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(qyu_pkg::SUM_W-1){1'b1}}};
  localparam logic signed [qyu_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(qyu_pkg::SUM_W-1){1'b0}}};

  qyu_pkg::state_e state_q, state_d;
  qyu_pkg::cordic_res_t cordic_res;

  logic [MUL_CNT_W-1:0]                cnt_q, cnt_d;
  logic                                op_q, op_d;
  logic signed [qyu_pkg::IN_W-1:0]     v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic signed [qyu_pkg::IN_W-1:0]     mul_a, mul_b;
  logic signed [qyu_pkg::PROD_W-1:0]   mul_q, mul_d;
  logic signed [qyu_pkg::SQ_W-1:0]     s11_q, s11_d, s22_q, s22_d, s33_q, s33_d, s12_q, s12_d;
  logic signed [qyu_pkg::SQ_W-1:0]     prod_q30, sw3;
  logic signed [qyu_pkg::TERM_W-1:0]   sq_sum, w2;
  logic [qyu_pkg::QFRAC:0]             w2_cl;
  logic [qyu_pkg::RAD_W-1:0]           rem_q, rem_d, root_q, root_d, sq_bit_q, sq_bit_d, trial;
  logic signed [qyu_pkg::TERM_W-1:0]   t3_q, t3_d, t4_q, t4_d;
  logic                                cordic_start;
  logic signed [qyu_pkg::YAW_W-1:0]    yaw_q, yaw_d;
  logic signed [qyu_pkg::DIFF_W-1:0]   diff_raw, diff_w;
  logic signed [SUM_EXT_W-1:0]         sum_ext, rel_ext;
  logic signed [qyu_pkg::SUM_W-1:0]    sum_new_q, sum_new_d, rel_sat;
  logic                                hit_q, hit_d, rel_hit;
  logic                                have_prev_q, have_prev_d;
  logic signed [qyu_pkg::YAW_W-1:0]    prev_yaw_q, prev_yaw_d;
  logic signed [qyu_pkg::SUM_W-1:0]    sum_q, sum_d, offset_q, offset_d;
  logic                                out_valid_q, out_valid_d;
  logic signed [qyu_pkg::SUM_W-1:0]    rel_out_q, rel_out_d;
  logic signed [qyu_pkg::YAW_W-1:0]    ywr_out_q, ywr_out_d;
  logic                                first_out_q, first_out_d, sat_out_q, sat_out_d;

  qyu_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .num_i   (t3_q),
    .den_i   (t4_q),
    .res_o   (cordic_res)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = v1_q;
    mul_b = v1_q;
    if (state_q == qyu_pkg::ST_MULW) begin
      mul_a = $signed(qyu_pkg::IN_W'(root_q[qyu_pkg::QFRAC:0]));
      mul_b = v3_q;
    end else begin
      case (cnt_q)
        PRD_V22: begin
          mul_a = v2_q;
          mul_b = v2_q;
        end
        PRD_V33: begin
          mul_a = v3_q;
          mul_b = v3_q;
        end
        PRD_V12: begin
          mul_a = v1_q;
          mul_b = v2_q;
        end
        default: begin
          mul_a = v1_q;
          mul_b = v1_q;
        end
      endcase
    end
  end

  assign mul_d    = mul_a * mul_b;
  assign prod_q30 = qyu_pkg::SQ_W'(mul_q >>> qyu_pkg::QFRAC);
  // z is -v3, so negate before the floor shift
  assign sw3      = qyu_pkg::SQ_W'((-mul_q) >>> qyu_pkg::QFRAC);

  assign sq_sum = qyu_pkg::TERM_W'(s11_q) + qyu_pkg::TERM_W'(s22_q) + qyu_pkg::TERM_W'(s33_q);
  assign w2     = TERM_ONE - sq_sum;
  assign w2_cl  = (w2 < 0) ? '0 : w2[qyu_pkg::QFRAC:0];
  assign trial  = root_q + sq_bit_q;

  // shortest signed step, then saturating accumulate
  always_comb begin
    diff_raw = qyu_pkg::DIFF_W'(yaw_q) - qyu_pkg::DIFF_W'(prev_yaw_q);
    diff_w   = diff_raw;
    if (diff_raw > HALF_DIFF) begin
      diff_w = diff_raw - FULL_DIFF;
    end else if (diff_raw <= -HALF_DIFF) begin
      diff_w = diff_raw + FULL_DIFF;
    end
  end

  assign sum_ext = SUM_EXT_W'(sum_q) + SUM_EXT_W'(diff_w);
  assign rel_ext = SUM_EXT_W'(sum_new_q) - SUM_EXT_W'(offset_q);
  assign rel_hit = rel_ext[SUM_EXT_W-1] != rel_ext[SUM_EXT_W-2];
  assign rel_sat = rel_hit ? (rel_ext[SUM_EXT_W-1] ? SUM_MIN : SUM_MAX)
                           : qyu_pkg::SUM_W'(rel_ext);

  assign in_stall_o   = (state_q != qyu_pkg::ST_IDLE);
  assign cordic_start = (state_q == qyu_pkg::ST_START);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    v3_d        = v3_q;
    s11_d       = s11_q;
    s22_d       = s22_q;
    s33_d       = s33_q;
    s12_d       = s12_q;
    rem_d       = rem_q;
    root_d      = root_q;
    sq_bit_d    = sq_bit_q;
    t3_d        = t3_q;
    t4_d        = t4_q;
    yaw_d       = yaw_q;
    sum_new_d   = sum_new_q;
    hit_d       = hit_q;
    have_prev_d = have_prev_q;
    prev_yaw_d  = prev_yaw_q;
    sum_d       = sum_q;
    offset_d    = offset_q;
    out_valid_d = out_valid_q & out_stall_i;
    rel_out_d   = rel_out_q;
    ywr_out_d   = ywr_out_q;
    first_out_d = first_out_q;
    sat_out_d   = sat_out_q;
    unique case (state_q)
      qyu_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          v1_d    = quat_v1_i;
          v2_d    = quat_v2_i;
          v3_d    = quat_v3_i;
          cnt_d   = '0;
          state_d = opcode_i ? qyu_pkg::ST_DONE : qyu_pkg::ST_MUL;
        end
      end
      qyu_pkg::ST_MUL: begin
        // mul_q holds the product issued in the previous cycle
        case (cnt_q)
          PRD_V22:  s11_d = prod_q30;
          PRD_V33:  s22_d = prod_q30;
          PRD_V12:  s33_d = prod_q30;
          PRD_LAST: s12_d = prod_q30;
          default:  s11_d = s11_q;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == PRD_LAST) begin
          state_d = qyu_pkg::ST_W2;
        end
      end
      qyu_pkg::ST_W2: begin
        rem_d    = qyu_pkg::RAD_W'(w2_cl) << qyu_pkg::QFRAC;
        root_d   = '0;
        sq_bit_d = qyu_pkg::RAD_W'(1) << (qyu_pkg::RAD_W - 1);
        state_d  = qyu_pkg::ST_SQRT;
      end
      qyu_pkg::ST_SQRT: begin
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + sq_bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        if (sq_bit_q[0]) begin
          state_d = qyu_pkg::ST_MULW;
        end
      end
      qyu_pkg::ST_MULW: begin
        state_d = qyu_pkg::ST_TERMS;
      end
      qyu_pkg::ST_TERMS: begin
        t3_d    = (qyu_pkg::TERM_W'(sw3) + qyu_pkg::TERM_W'(s12_q)) <<< 1;
        t4_d    = TERM_ONE - ((qyu_pkg::TERM_W'(s11_q) + qyu_pkg::TERM_W'(s33_q)) <<< 1);
        state_d = qyu_pkg::ST_START;
      end
      qyu_pkg::ST_START: begin
        state_d = qyu_pkg::ST_WAIT;
      end
      qyu_pkg::ST_WAIT: begin
        if (cordic_res.done) begin
          yaw_d   = cordic_res.yaw;
          state_d = qyu_pkg::ST_UNWRAP;
        end
      end
      qyu_pkg::ST_UNWRAP: begin
        hit_d = sum_ext[SUM_EXT_W-1] != sum_ext[SUM_EXT_W-2];
        if (hit_d) begin
          sum_new_d = sum_ext[SUM_EXT_W-1] ? SUM_MIN : SUM_MAX;
        end else begin
          sum_new_d = qyu_pkg::SUM_W'(sum_ext);
        end
        state_d = qyu_pkg::ST_DONE;
      end
      qyu_pkg::ST_DONE: begin
        // hold here until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = qyu_pkg::ST_IDLE;
          if (op_q) begin
            offset_d    = sum_q;
            rel_out_d   = '0;
            ywr_out_d   = prev_yaw_q;
            first_out_d = 1'b0;
            sat_out_d   = 1'b0;
          end else if (!have_prev_q) begin
            have_prev_d = 1'b1;
            prev_yaw_d  = yaw_q;
            sum_d       = '0;
            offset_d    = '0;
            rel_out_d   = '0;
            ywr_out_d   = yaw_q;
            first_out_d = 1'b1;
            sat_out_d   = 1'b0;
          end else begin
            prev_yaw_d  = yaw_q;
            sum_d       = sum_new_q;
            rel_out_d   = rel_sat;
            ywr_out_d   = yaw_q;
            first_out_d = 1'b0;
            sat_out_d   = hit_q | rel_hit;
          end
        end
      end
      default: state_d = qyu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qyu_pkg::ST_IDLE;
      cnt_q       <= '0;
      have_prev_q <= 1'b0;
      prev_yaw_q  <= '0;
      sum_q       <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      have_prev_q <= have_prev_d;
      prev_yaw_q  <= prev_yaw_d;
      sum_q       <= sum_d;
      offset_q    <= offset_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    v1_q        <= v1_d;
    v2_q        <= v2_d;
    v3_q        <= v3_d;
    mul_q       <= mul_d;
    s11_q       <= s11_d;
    s22_q       <= s22_d;
    s33_q       <= s33_d;
    s12_q       <= s12_d;
    rem_q       <= rem_d;
    root_q      <= root_d;
    sq_bit_q    <= sq_bit_d;
    t3_q        <= t3_d;
    t4_q        <= t4_d;
    yaw_q       <= yaw_d;
    sum_new_q   <= sum_new_d;
    hit_q       <= hit_d;
    rel_out_q   <= rel_out_d;
    ywr_out_q   <= ywr_out_d;
    first_out_q <= first_out_d;
    sat_out_q   <= sat_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign yaw_relative_o = rel_out_q;
  assign yaw_wrapped_o  = ywr_out_q;
  assign first_sample_o = first_out_q;
  assign saturated_o    = sat_out_q;

endmodule

// File: sv/qyu_checker.sv
// Port-level checker for the yaw tracker, attached to the top level by bind.
// Depends on qyu_pkg and quat_yaw_unwrap_tracker_macros.svh.
`include "quat_yaw_unwrap_tracker_macros.svh"

module qyu_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [qyu_pkg::SUM_W-1:0]  yaw_relative_o,
  input logic signed [qyu_pkg::YAW_W-1:0]  yaw_wrapped_o,
  input logic                              first_sample_o,
  input logic                              saturated_o
);

  // one beat at a time: busy straight after an accept
  `QYU_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted beat did not make the block busy")

  `QYU_ASSERT_NOW(a_first_is_zero, out_valid_o && first_sample_o, yaw_relative_o == '0 && !saturated_o, "first sample must report zero yaw without saturation")

  `QYU_ASSERT_NOW(a_wrapped_range, out_valid_o, yaw_wrapped_o <= qyu_pkg::YAW_LIM && yaw_wrapped_o >= -qyu_pkg::YAW_LIM, "wrapped yaw outside half-turn range")

  `QYU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(yaw_relative_o) && $stable(yaw_wrapped_o), "stalled result beat changed")

endmodule

bind quat_yaw_unwrap_tracker qyu_checker u_qyu_checker (.*);

// File: test/yaw_track_monitor.sv
// Checker for the quaternion yaw tracker: watches both channels, predicts every result
// beat from the accepted input beats and compares field by field. Needs only the port list.
`timescale 1ns / 1ps

package yaw_tb_pkg;
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_ZERO   = 1'b1
  } yaw_op_e;
endpackage

module yaw_track_monitor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               opcode_i,
  input  logic signed [31:0] quat_v1_i,
  input  logic signed [31:0] quat_v2_i,
  input  logic signed [31:0] quat_v3_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [39:0] yaw_relative_i,
  input  logic signed [24:0] yaw_wrapped_i,
  input  logic               first_sample_i,
  input  logic               saturated_i,
  output int                 fault_count_o,
  output int                 pending_o
);

  localparam int     ROTATIONS = 20;
  localparam int     DEG_FRAC  = 16;
  localparam int     TAB_Q     = 24;
  localparam longint ONE_Q30   = longint'(1) << 30;
  localparam longint HALF_DEG  = longint'(180) << DEG_FRAC;
  localparam longint FULL_DEG  = longint'(360) << DEG_FRAC;
  localparam longint HALF_TAB  = longint'(180) << TAB_Q;
  localparam longint SUM_MAX   = (longint'(1) << 39) - 1;
  localparam longint SUM_MIN   = -(longint'(1) << 39);

  typedef struct packed {
    logic signed [39:0] rel;
    logic signed [24:0] wrapped;
    logic               first;
    logic               sat;
  } yaw_beat_t;

  // atan(2^-i) in degrees, Q24
  longint arctan_q24 [0:31] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  yaw_beat_t          due_q[$];
  logic               seen_first;
  logic signed [24:0] prev_yaw;
  logic signed [39:0] sum_q;
  logic signed [39:0] offset_q;
  int                 faults;
  int                 beats;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // atan2(num, den) in Q16 degrees, rotation by rotation
  function automatic longint cordic_heading(longint num, longint den);
    longint ang;
    longint xs;
    longint ys;
    longint nx;
    longint ny;
    longint r;
    if (num == 0) return (den < 0) ? HALF_DEG : 0;
    ang = 0;
    xs  = den;
    ys  = num;
    if (xs < 0) begin
      ang = (ys > 0) ? HALF_TAB : -HALF_TAB;
      xs  = -xs;
      ys  = -ys;
    end
    xs = xs * (longint'(1) << 20);
    ys = ys * (longint'(1) << 20);
    for (int i = 0; i < ROTATIONS; i++) begin
      if (ys > 0) begin
        nx  = xs + (ys >>> i);
        ny  = ys - (xs >>> i);
        ang += arctan_q24[i];
      end else begin
        nx  = xs - (ys >>> i);
        ny  = ys + (xs >>> i);
        ang -= arctan_q24[i];
      end
      xs = nx;
      ys = ny;
    end
    r = (ang + (longint'(1) << (TAB_Q - DEG_FRAC - 1))) >>> (TAB_Q - DEG_FRAC);
    if (r > HALF_DEG) r = HALF_DEG;
    if (r < -HALF_DEG) r = -HALF_DEG;
    return r;
  endfunction

  function automatic longint sample_heading(logic signed [31:0] a1, logic signed [31:0] a2,
                                            logic signed [31:0] a3);
    longint w2;
    longint w;
    longint x;
    longint y;
    longint z;
    longint num;
    longint den;
    y  = a1;
    x  = a2;
    z  = -longint'(a3);
    w2 = ONE_Q30 - (((y * y) >>> 30) + ((x * x) >>> 30) + ((z * z) >>> 30));
    if (w2 < 0) w2 = 0;
    if (w2 > ONE_Q30) w2 = ONE_Q30;
    w   = longint'(int_sqrt(longint'(w2) << 30));
    num = 2 * (((w * z) >>> 30) + ((x * y) >>> 30));
    den = ONE_Q30 - 2 * (((y * y) >>> 30) + ((z * z) >>> 30));
    return cordic_heading(num, den);
  endfunction

  function automatic longint clamp40(longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  function automatic yaw_beat_t advance_tracker(yaw_tb_pkg::yaw_op_e op,
                                                logic signed [31:0] a1,
                                                logic signed [31:0] a2, logic signed [31:0] a3);
    yaw_beat_t res;
    longint    heading;
    longint    d;
    longint    acc;
    res = '0;
    if (op == yaw_tb_pkg::OP_ZERO) begin
      offset_q    = sum_q;
      res.wrapped = prev_yaw;
    end else begin
      heading = sample_heading(a1, a2, a3);
      if (!seen_first) begin
        seen_first = 1'b1;
        sum_q      = '0;
        offset_q   = '0;
        res.first  = 1'b1;
      end else begin
        d = heading - longint'(prev_yaw);
        if (d > HALF_DEG) d -= FULL_DEG;
        if (d <= -HALF_DEG) d += FULL_DEG;
        acc = longint'(sum_q) + d;
        if (acc != clamp40(acc)) res.sat = 1'b1;
        sum_q = 40'(clamp40(acc));
        acc   = longint'(sum_q) - longint'(offset_q);
        if (acc != clamp40(acc)) res.sat = 1'b1;
        res.rel = 40'(clamp40(acc));
      end
      prev_yaw    = 25'(heading);
      res.wrapped = 25'(heading);
    end
    return res;
  endfunction

  task automatic report_fault(string msg);
    faults++;
    if (faults <= 100) $display("ERROR: result beat %0d: %s", beats, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    yaw_beat_t want;
    if (!rst_ni) begin
      seen_first = 1'b0;
      prev_yaw   = '0;
      sum_q      = '0;
      offset_q   = '0;
      faults     = 0;
      beats      = 0;
      due_q.delete();
      fault_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        due_q.push_back(advance_tracker(yaw_tb_pkg::yaw_op_e'(opcode_i), quat_v1_i,
                                        quat_v2_i, quat_v3_i));
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          report_fault($sformatf("beat with nothing outstanding, yaw_relative %0d",
                                 yaw_relative_i));
        end else begin
          want = due_q.pop_front();
          if (yaw_relative_i !== want.rel)
            report_fault($sformatf("yaw_relative got %0d want %0d", yaw_relative_i, want.rel));
          if (yaw_wrapped_i !== want.wrapped)
            report_fault($sformatf("yaw_wrapped got %0d want %0d", yaw_wrapped_i,
                                   want.wrapped));
          if (first_sample_i !== want.first)
            report_fault($sformatf("first_sample got %b want %b", first_sample_i, want.first));
          if (saturated_i !== want.sat)
            report_fault($sformatf("saturated got %b want %b", saturated_i, want.sat));
        end
        beats++;
      end
      fault_count_o <= faults;
      pending_o     <= due_q.size();
    end
  end

endmodule

// File: test/tb_top.sv
// Top of the yaw tracker testbench: clock, reset, stimulus and flow control on both channels.
// Depends on qyu_pkg, quat_yaw_unwrap_tracker and yaw_track_monitor (with yaw_tb_pkg).
`timescale 1ns / 1ps

module tb_top;

  localparam int          LIMIT_CYCLES = 500000;
  localparam int          NUM_RANDOM   = 1000;
  localparam logic [31:0] Q30_POS      = 32'h4000_0000;
  localparam logic [31:0] Q30_NEG      = 32'hC000_0000;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               opcode_i       = 1'b0;
  logic signed [31:0] quat_v1_i      = '0;
  logic signed [31:0] quat_v2_i      = '0;
  logic signed [31:0] quat_v3_i      = '0;
  logic               out_stall_i    = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic signed [39:0] yaw_relative_o;
  logic signed [24:0] yaw_wrapped_o;
  logic               first_sample_o;
  logic               saturated_o;
  int                 faults;
  int                 pending;
  int                 cycles         = 0;
  int                 sent           = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  quat_yaw_unwrap_tracker DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .quat_v1_i      (quat_v1_i),
    .quat_v2_i      (quat_v2_i),
    .quat_v3_i      (quat_v3_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .yaw_relative_o (yaw_relative_o),
    .yaw_wrapped_o  (yaw_wrapped_o),
    .first_sample_o (first_sample_o),
    .saturated_o    (saturated_o)
  );

  yaw_track_monitor u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .opcode_i       (opcode_i),
    .quat_v1_i      (quat_v1_i),
    .quat_v2_i      (quat_v2_i),
    .quat_v3_i      (quat_v3_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .yaw_relative_i (yaw_relative_o),
    .yaw_wrapped_i  (yaw_wrapped_o),
    .first_sample_i (first_sample_o),
    .saturated_i    (saturated_o),
    .fault_count_o  (faults),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] any_q30();
    logic [31:0] u;
    u = $urandom_range(0, 32'h8000_0000);
    return signed'(u - Q30_POS);
  endfunction

  function automatic logic signed [31:0] tilt_q30();
    logic [31:0] u;
    u = $urandom_range(0, 32'h0080_0000);
    return signed'(u - 32'h0040_0000);
  endfunction

  // Third vector part for a pure rotation about the vertical axis by deg degrees
  function automatic logic signed [31:0] yaw_part(real deg);
    real h;
    h = deg;
    while (h > 180.0) h -= 360.0;
    while (h <= -180.0) h += 360.0;
    return $rtoi(-$sin(h * 3.14159265358979 / 360.0) * 1073741824.0);
  endfunction

  function automatic logic [31:0] corner_q30();
    case ($urandom_range(0, 3))
      0:       return Q30_NEG;
      1:       return Q30_POS;
      2:       return '0;
      default: return any_q30();
    endcase
  endfunction

  task automatic offer(yaw_tb_pkg::yaw_op_e op, logic signed [31:0] a1,
                       logic signed [31:0] a2, logic signed [31:0] a3);
    int gap;
    gap = (((sent / 90) % 4) == 2) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    quat_v1_i  <= a1;
    quat_v2_i  <= a2;
    quat_v3_i  <= a3;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  // drop valid so the last beat is not taken twice while waiting
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Receiver: random hold-off per beat, bursts without any, and one long hold to back
  // the block up into its input
  initial begin
    int n;
    int taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      if (taken == 120)
        n = 400;
      else if (((taken / 80) % 4) == 1)
        n = 0;
      else
        n = $urandom_range(0, 13);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin
    real heading;
    int  pick;
    int  stride;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero before any sample, first sample, exact half-turn cases and wrap-around
    offer(yaw_tb_pkg::OP_ZERO, 32'sd7, -32'sd5, 32'sd3);
    offer(yaw_tb_pkg::OP_SAMPLE, '0, '0, '0);
    offer(yaw_tb_pkg::OP_ZERO, Q30_NEG, Q30_POS, Q30_NEG);
    offer(yaw_tb_pkg::OP_SAMPLE, Q30_POS, '0, '0);
    offer(yaw_tb_pkg::OP_SAMPLE, '0, '0, '0);
    offer(yaw_tb_pkg::OP_SAMPLE, '0, Q30_POS, '0);
    offer(yaw_tb_pkg::OP_SAMPLE, '0, '0, Q30_POS);
    offer(yaw_tb_pkg::OP_SAMPLE, '0, '0, Q30_NEG);
    offer(yaw_tb_pkg::OP_SAMPLE, Q30_NEG, Q30_NEG, Q30_NEG);
    offer(yaw_tb_pkg::OP_SAMPLE, Q30_POS, Q30_POS, Q30_POS);
    offer(yaw_tb_pkg::OP_SAMPLE, '0, '0, yaw_part(90.0));
    offer(yaw_tb_pkg::OP_SAMPLE, '0, '0, yaw_part(-90.0));
    offer(yaw_tb_pkg::OP_SAMPLE, '0, '0, yaw_part(179.0));
    offer(yaw_tb_pkg::OP_SAMPLE, '0, '0, yaw_part(-179.0));
    offer(yaw_tb_pkg::OP_SAMPLE, '0, '0, yaw_part(179.0));
    offer(yaw_tb_pkg::OP_ZERO, any_q30(), any_q30(), any_q30());
    offer(yaw_tb_pkg::OP_ZERO, '0, '0, '0);
    offer(yaw_tb_pkg::OP_SAMPLE, '0, '0, yaw_part(45.0));
    offer(yaw_tb_pkg::OP_SAMPLE, Q30_NEG, Q30_POS, '0);
    offer(yaw_tb_pkg::OP_SAMPLE, Q30_NEG, Q30_NEG, Q30_POS);
    offer(yaw_tb_pkg::OP_SAMPLE, 32'sd1, -32'sd1, 32'sd1);
    offer(yaw_tb_pkg::OP_SAMPLE, -32'sd1, '0, '0);
    drain_results();

    heading = 0.0;
    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k == NUM_RANDOM / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        offer(yaw_tb_pkg::OP_ZERO, any_q30(), any_q30(), any_q30());
      end else if (pick < 15) begin
        offer(yaw_tb_pkg::OP_SAMPLE, any_q30(), any_q30(), any_q30());
      end else if (pick < 18) begin
        offer(yaw_tb_pkg::OP_SAMPLE, corner_q30(), corner_q30(), corner_q30());
      end else begin
        // steady turning with a forward drift, now and then a large jump
        if ($urandom_range(0, 9) == 0)
          stride = $urandom_range(0, 358) - 179;
        else
          stride = $urandom_range(0, 60) - 25;
        heading += stride + $urandom_range(0, 999) / 1000.0;
        while (heading > 180.0) heading -= 360.0;
        while (heading <= -180.0) heading += 360.0;
        offer(yaw_tb_pkg::OP_SAMPLE, tilt_q30(), tilt_q30(), yaw_part(heading));
      end
    end

    drain_results();
    repeat (80) @(posedge clk_i);
    if (faults == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
